// ===== sv/sm3_pkg.sv =====
package sm3_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] blk_t;
  typedef logic [7:0][31:0] chain_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_digest;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BLK, ST_C1, ST_PAD, ST_C2, ST_LEN, ST_C3, ST_OUT
  } state_t;

  localparam chain_t SM3_IV = {
    32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
    32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
  };
  localparam word_t T_LO      = 32'h79cc4519;
  localparam word_t T_HI_ROT  = 32'h9d8a7a87;  // 7a879d8a rotated left by 16
  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t rol(input word_t x, input int n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t p0(input word_t x);
    p0 = x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic word_t p1(input word_t x);
    p1 = x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

endpackage

// ===== sv/sm3_front.sv =====
module sm3_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  sm3_pkg::in_item_t in_item,
  input  logic              q_pop,
  output logic              q_empty,
  output sm3_pkg::in_item_t q_item
);
  import sm3_pkg::*;

  in_item_t   slot_r [2];
  in_item_t   cls;
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       do_push, do_pop;
  logic [2:0] n_sat;
  word_t      mask;

  always_comb begin
    n_sat = (!in_item.last_word || in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;
    case (n_sat)
      3'd0:    mask = 32'h00000000;
      3'd1:    mask = 32'hff000000;
      3'd2:    mask = 32'hffff0000;
      3'd3:    mask = 32'hffffff00;
      default: mask = 32'hffffffff;
    endcase
    cls.data_word  = in_item.data_word & mask;
    cls.byte_count = n_sat;
    cls.last_word  = in_item.last_word;
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_item  = slot_r[rd_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= ~wr_r;
      if (do_pop)  rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= cls;
  end

endmodule

// ===== sv/sm3_compress.sv =====
module sm3_round_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            init,
  input  logic            start,
  input  sm3_pkg::blk_t   blk,
  output logic            done,
  output sm3_pkg::chain_t chain
);
  import sm3_pkg::*;

  chain_t     chain_r;
  chain_t     v_r, v_nxt;
  blk_t       win_r;
  word_t      t_r;
  logic [5:0] j_r;
  logic       run_r, fin_r;
  word_t      a12, ss1, ss2, ff, gg, tt1, tt2, wn;
  logic       early;

  assign chain = chain_r;
  assign done  = fin_r;

  always_comb begin
    early = (j_r < 6'd16);
    a12 = rol(v_r[0], 12);
    ss1 = rol(a12 + v_r[4] + t_r, 7);
    ss2 = ss1 ^ a12;
    ff  = early ? (v_r[0] ^ v_r[1] ^ v_r[2])
                : ((v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]));
    gg  = early ? (v_r[4] ^ v_r[5] ^ v_r[6]) : ((v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]));
    tt1 = ff + v_r[3] + ss2 + (win_r[0] ^ win_r[4]);
    tt2 = gg + v_r[7] + ss1 + win_r[0];
    v_nxt[0] = tt1;
    v_nxt[1] = v_r[0];
    v_nxt[2] = rol(v_r[1], 9);
    v_nxt[3] = v_r[2];
    v_nxt[4] = p0(tt2);
    v_nxt[5] = v_r[4];
    v_nxt[6] = rol(v_r[5], 19);
    v_nxt[7] = v_r[6];
    wn = p1(win_r[0] ^ win_r[7] ^ rol(win_r[13], 15)) ^ rol(win_r[3], 7) ^ win_r[10];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      fin_r   <= 1'b0;
      j_r     <= '0;
      chain_r <= SM3_IV;
    end else begin
      fin_r <= 1'b0;
      if (init) begin
        chain_r <= SM3_IV;
      end else if (fin_r) begin
        chain_r <= chain_r ^ v_r;
      end
      if (start) begin
        run_r <= 1'b1;
        j_r   <= '0;
      end else if (run_r) begin
        j_r <= j_r + 6'd1;
        if (j_r == 6'd63) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= chain_r;
      win_r <= blk;
      t_r   <= T_LO;
    end else if (run_r) begin
      v_r   <= v_nxt;
      win_r <= {wn, win_r[15:1]};
      t_r   <= (j_r == 6'd15) ? T_HI_ROT : rol(t_r, 1);
    end
  end

endmodule

// ===== sv/sm3_hash_engine.sv =====
// SM3 hash engine, 256-bit digest.
// Input queue: in_item (data_word big-endian, byte_count, last_word) is
// transferred when in_push is high and in_full is low. Words not marked
// last count as four bytes; the last word carries 0 to 4 leading bytes.
// A two-entry front queue masks and classifies words; the back end fills
// a 16-word block buffer and runs one SM3 round per cycle.
// Each full block is compressed in 64 rounds plus load and feed-forward;
// no new word is taken from the front queue while that block is compressed.
// On the last word the back end pads, runs one or two more compressions
// (two when the last word fills the block or the pad does not fit before
// the length field), then presents eight digest words on out_item while
// out_empty is low, word 0 first; out_pop transfers each one.
// While results wait, no new word is taken from the front queue; once it
// fills, in_full stays high until the receiver pops all eight words.
// After the eighth word the chaining value returns to the initial value.
// Reset (rst_n low, synchronous) empties both sides and loads the IV.
module sm3_hash_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  sm3_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output sm3_pkg::out_item_t out_item
);
  import sm3_pkg::*;

  state_t      state_r, state_nxt;
  in_item_t    q_item;
  logic        q_empty, q_pop;
  blk_t        buf_r, buf_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [60:0] len_r, len_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        started_r;
  logic        start, done, init, waiting;
  chain_t      chain;
  logic [63:0] bits;
  word_t       pad;

  sm3_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_item  (q_item)
  );

  sm3_round_unit u_comp (
    .clk   (clk),
    .rst_n (rst_n),
    .init  (init),
    .start (start),
    .blk   (buf_r),
    .done  (done),
    .chain (chain)
  );

  assign bits = {len_r, 3'b000};

  always_comb begin
    case (pos_r[1:0])
      2'd0:    pad = {PAD_BYTE, 24'h0};
      2'd1:    pad = {8'h0, PAD_BYTE, 16'h0};
      2'd2:    pad = {16'h0, PAD_BYTE, 8'h0};
      default: pad = {24'h0, PAD_BYTE};
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (!q_item.last_word) begin
            state_nxt = (fill_r == 4'd15) ? ST_BLK : ST_IDLE;
          end else begin
            state_nxt = (fill_r == 4'd15 && q_item.byte_count == 3'd4) ? ST_C1 : ST_PAD;
          end
        end
      end
      ST_BLK:  if (done) state_nxt = ST_IDLE;
      ST_C1:   if (done) state_nxt = ST_PAD;
      ST_PAD:  state_nxt = (pos_r >= 6'd56) ? ST_C2 : ST_LEN;
      ST_C2:   if (done) state_nxt = ST_LEN;
      ST_LEN:  state_nxt = ST_C3;
      ST_C3:   if (done) state_nxt = ST_OUT;
      ST_OUT:  if (out_pop && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop     = 1'b0;
    waiting   = 1'b0;
    init      = 1'b0;
    out_empty = 1'b1;
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    oidx_nxt  = oidx_r;
    case (state_r)
      ST_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty) begin
          buf_nxt[fill_r] = q_item.data_word;
          len_nxt  = len_r + 61'(q_item.byte_count);
          fill_nxt = fill_r + 4'd1;
          pos_nxt  = {fill_r, 2'b00} + 6'(q_item.byte_count);
        end
      end
      ST_BLK, ST_C3: waiting = 1'b1;
      ST_C1: begin
        waiting = 1'b1;
        if (done) pos_nxt = '0;
      end
      ST_PAD: begin
        for (int i = 0; i < 16; i++) begin
          if (4'(i) > pos_r[5:2]) begin
            buf_nxt[i] = '0;
          end else if (4'(i) == pos_r[5:2]) begin
            buf_nxt[i] = ((pos_r[1:0] == 2'd0) ? 32'h0 : buf_r[i]) | pad;
          end
        end
      end
      ST_C2: begin
        waiting = 1'b1;
        if (done) buf_nxt = '0;
      end
      ST_LEN: begin
        buf_nxt[14] = bits[63:32];
        buf_nxt[15] = bits[31:0];
      end
      ST_OUT: begin
        out_empty = 1'b0;
        if (out_pop) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            init     = 1'b1;
            fill_nxt = '0;
            len_nxt  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign start = waiting && !started_r;

  assign out_item.digest_word = chain[oidx_r];
  assign out_item.word_index  = oidx_r;
  assign out_item.last_digest = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      len_r     <= '0;
      oidx_r    <= '0;
      started_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      oidx_r  <= oidx_nxt;
      if (start) begin
        started_r <= 1'b1;
      end else if (done) begin
        started_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    pos_r <= pos_nxt;
  end

endmodule
